FILE: rtl/trilateration_2d_solver_top_assert.svh
// Assertion macros for the trilateration solver top level.
`ifndef TRILATERATION_2D_SOLVER_TOP_ASSERT_SVH
`define TRILATERATION_2D_SOLVER_TOP_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define TRI2D_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that applies whenever a result is presented.
`define TRI2D_CHECK_OUT(lbl, cond, msg) \
    `TRI2D_CHECK(lbl, out_valid |-> (cond), msg)

`endif

FILE: rtl/tri2d_pkg.sv
// Types and constants of the 2D trilateration solver.
`default_nettype none
package tri2d_pkg;

    localparam int COORD_W = 24;
    localparam int RANGE_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int A_W     = COORD_W + 2;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int RSQ_W   = 2 * RANGE_W;
    localparam int B_W     = ((SQ_W > RSQ_W) ? SQ_W : RSQ_W) + 2;
    localparam int B_LO_W  = B_W / 2;
    localparam int B_HI_W  = B_W - B_LO_W;
    localparam int DET_W   = 2 * A_W + 1;
    localparam int NUM_W   = B_W + A_W + 1;
    localparam int Q_W     = COORD_W + 1;
    localparam int DIV_W   = (NUM_W > DET_W + Q_W) ? NUM_W : DET_W + Q_W;
    localparam int NUM_REGS = 6;
    localparam int IDX_W    = 3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_ANCHOR1_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_ANCHOR1_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_ANCHOR2_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_ANCHOR2_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_ANCHOR3_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_ANCHOR3_Y = 3'd5;

    typedef struct packed {
        logic [RANGE_W-1:0] range_to_first;
        logic [RANGE_W-1:0] range_to_second;
        logic [RANGE_W-1:0] range_to_third;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] tag_x;
        logic signed [COORD_W-1:0] tag_y;
        logic                      singular;
        logic                      saturated;
    } out_t;

    // One entry of the divider pipeline, carrying both Cramer quotients.
    typedef struct packed {
        logic [DIV_W-1:0] rem_x;
        logic [DIV_W-1:0] rem_y;
        logic [Q_W-1:0]   q_x;
        logic [Q_W-1:0]   q_y;
        logic [DET_W-1:0] dv;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic             singular;
    } div_t;

endpackage
`default_nettype wire

FILE: rtl/trilateration_2d_solver_top.sv
// Top level of the pipelined 2D trilateration solver.
// The solver takes one range request per clock unless the output stalls, and returns one position
// per request in order. The position is presented through 32 register stages: six stages form
// the linearized system, its determinant and both Cramer numerators, 25 stages each retire one
// quotient bit of the two divisions, and one stage saturates and registers the result.
// Anchor positions are to be written through the configuration port only while no request is in
// flight; the block itself does not enforce this.
`default_nettype none
module trilateration_2d_solver_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire tri2d_pkg::in_t              in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output tri2d_pkg::out_t                  out_data,
    input  wire logic                        cfg_write,
    input  wire logic [tri2d_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [tri2d_pkg::COORD_W-1:0] cfg_data
);

    localparam int CW  = tri2d_pkg::COORD_W;
    localparam int QW  = tri2d_pkg::Q_W;
    localparam int AW  = tri2d_pkg::A_W;
    localparam int BW  = tri2d_pkg::B_W;
    localparam int BL  = tri2d_pkg::B_LO_W;
    localparam int BH  = tri2d_pkg::B_HI_W;
    localparam int NW  = tri2d_pkg::NUM_W;
    localparam int DTW = tri2d_pkg::DET_W;
    localparam int SQW = tri2d_pkg::SQ_W;
    localparam int RQW = tri2d_pkg::RSQ_W;
    localparam int DFW = tri2d_pkg::DIFF_W;
    localparam int LOP = BL + 1 + AW;
    localparam int HIP = BH + AW;
    localparam logic [QW-1:0] Q_HALF = QW'(1) << (CW - 1);
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    // Anchor registers.
    logic signed [CW-1:0] anchor_reg [tri2d_pkg::NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tri2d_pkg::NUM_REGS; i++)
            begin
                anchor_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tri2d_pkg::REG_ANCHOR1_X: anchor_reg[0] <= cfg_data;
                tri2d_pkg::REG_ANCHOR1_Y: anchor_reg[1] <= cfg_data;
                tri2d_pkg::REG_ANCHOR2_X: anchor_reg[2] <= cfg_data;
                tri2d_pkg::REG_ANCHOR2_Y: anchor_reg[3] <= cfg_data;
                tri2d_pkg::REG_ANCHOR3_X: anchor_reg[4] <= cfg_data;
                tri2d_pkg::REG_ANCHOR3_Y: anchor_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valids and the backward ready chain.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, out_v_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;
    logic div_in_ready;

    logic            div_valid [QW+1];
    logic            div_ready [QW+1];
    tri2d_pkg::div_t div_data  [QW+1];

    assign rdy_out  = !out_v_reg || out_ready;
    assign rdy6     = !v6_reg || div_in_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)    v1_reg    <= in_valid;
            if (rdy2)    v2_reg    <= v1_reg;
            if (rdy3)    v3_reg    <= v2_reg;
            if (rdy4)    v4_reg    <= v3_reg;
            if (rdy5)    v5_reg    <= v4_reg;
            if (rdy6)    v6_reg    <= v5_reg;
            if (rdy_out) out_v_reg <= div_valid[QW];
        end
    end

    // Stage 1: range and anchor squares, matrix entries.
    logic        [RQW-1:0] r1_dsq_reg [3];
    logic signed [SQW-1:0] r1_csq_reg [6];
    logic signed [AW-1:0]  r1_a11_reg, r1_a12_reg, r1_a21_reg, r1_a22_reg;
    logic signed [DFW-1:0] dx2, dy2, dx3, dy3;

    assign dx2 = DFW'(anchor_reg[2]) - DFW'(anchor_reg[0]);
    assign dy2 = DFW'(anchor_reg[3]) - DFW'(anchor_reg[1]);
    assign dx3 = DFW'(anchor_reg[4]) - DFW'(anchor_reg[0]);
    assign dy3 = DFW'(anchor_reg[5]) - DFW'(anchor_reg[1]);

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            r1_dsq_reg[0] <= RQW'(in_data.range_to_first)  * RQW'(in_data.range_to_first);
            r1_dsq_reg[1] <= RQW'(in_data.range_to_second) * RQW'(in_data.range_to_second);
            r1_dsq_reg[2] <= RQW'(in_data.range_to_third)  * RQW'(in_data.range_to_third);
            for (int i = 0; i < 6; i++)
            begin
                r1_csq_reg[i] <= SQW'(anchor_reg[i]) * SQW'(anchor_reg[i]);
            end
            r1_a11_reg <= {dx2, 1'b0};
            r1_a12_reg <= {dy2, 1'b0};
            r1_a21_reg <= {dx3, 1'b0};
            r1_a22_reg <= {dy3, 1'b0};
        end
    end

    // Stage 2: right-hand side and determinant products.
    logic signed [BW-1:0]    r2_b1_reg, r2_b2_reg;
    logic signed [DTW-2:0]   r2_p1_reg, r2_p2_reg;
    logic signed [AW-1:0]    r2_a11_reg, r2_a12_reg, r2_a21_reg, r2_a22_reg;
    logic signed [BW-1:0]    base, ds1, ds2, ds3;

    always_comb
    begin
        ds1  = BW'($signed({1'b0, r1_dsq_reg[0]}));
        ds2  = BW'($signed({1'b0, r1_dsq_reg[1]}));
        ds3  = BW'($signed({1'b0, r1_dsq_reg[2]}));
        base = BW'(r1_csq_reg[0]) + BW'(r1_csq_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            r2_b1_reg  <= ds1 - ds2 + BW'(r1_csq_reg[2]) + BW'(r1_csq_reg[3]) - base;
            r2_b2_reg  <= ds1 - ds3 + BW'(r1_csq_reg[4]) + BW'(r1_csq_reg[5]) - base;
            r2_p1_reg  <= (DTW-1)'(r1_a11_reg) * (DTW-1)'(r1_a22_reg);
            r2_p2_reg  <= (DTW-1)'(r1_a12_reg) * (DTW-1)'(r1_a21_reg);
            r2_a11_reg <= r1_a11_reg;
            r2_a12_reg <= r1_a12_reg;
            r2_a21_reg <= r1_a21_reg;
            r2_a22_reg <= r1_a22_reg;
        end
    end

    // Stage 3: determinant and split partial products of both numerators.
    logic signed [DTW-1:0] r3_det_reg;
    logic signed [LOP-1:0] r3_lx1_reg, r3_lx2_reg, r3_ly1_reg, r3_ly2_reg;
    logic signed [HIP-1:0] r3_hx1_reg, r3_hx2_reg, r3_hy1_reg, r3_hy2_reg;
    logic signed [BL:0]    b1_lo, b2_lo;
    logic signed [BH-1:0]  b1_hi, b2_hi;

    assign b1_lo = $signed({1'b0, r2_b1_reg[BL-1:0]});
    assign b2_lo = $signed({1'b0, r2_b2_reg[BL-1:0]});
    assign b1_hi = $signed(r2_b1_reg[BW-1:BL]);
    assign b2_hi = $signed(r2_b2_reg[BW-1:BL]);

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            r3_det_reg <= DTW'(r2_p1_reg) - DTW'(r2_p2_reg);
            // x numerator: b1*a22 - a12*b2
            r3_lx1_reg <= LOP'(b1_lo) * LOP'(r2_a22_reg);
            r3_hx1_reg <= HIP'(b1_hi) * HIP'(r2_a22_reg);
            r3_lx2_reg <= LOP'(b2_lo) * LOP'(r2_a12_reg);
            r3_hx2_reg <= HIP'(b2_hi) * HIP'(r2_a12_reg);
            // y numerator: a11*b2 - a21*b1
            r3_ly1_reg <= LOP'(b2_lo) * LOP'(r2_a11_reg);
            r3_hy1_reg <= HIP'(b2_hi) * HIP'(r2_a11_reg);
            r3_ly2_reg <= LOP'(b1_lo) * LOP'(r2_a21_reg);
            r3_hy2_reg <= HIP'(b1_hi) * HIP'(r2_a21_reg);
        end
    end

    // Stage 4: assemble the numerators.
    logic signed [NW-1:0]  r4_nx_reg, r4_ny_reg;
    logic signed [DTW-1:0] r4_det_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            r4_nx_reg  <= (NW'(r3_hx1_reg) <<< BL) + NW'(r3_lx1_reg)
                        - (NW'(r3_hx2_reg) <<< BL) - NW'(r3_lx2_reg);
            r4_ny_reg  <= (NW'(r3_hy1_reg) <<< BL) + NW'(r3_ly1_reg)
                        - (NW'(r3_hy2_reg) <<< BL) - NW'(r3_ly2_reg);
            r4_det_reg <= r3_det_reg;
        end
    end

    // Stage 5: magnitudes, quotient signs and the singular flag.
    logic [NW-1:0]  r5_nx_reg, r5_ny_reg;
    logic [DTW-1:0] r5_dv_reg;
    logic           r5_neg_x_reg, r5_neg_y_reg, r5_sing_reg;

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
        begin
            r5_nx_reg    <= r4_nx_reg[NW-1] ? NW'(-r4_nx_reg) : NW'(r4_nx_reg);
            r5_ny_reg    <= r4_ny_reg[NW-1] ? NW'(-r4_ny_reg) : NW'(r4_ny_reg);
            r5_dv_reg    <= r4_det_reg[DTW-1] ? DTW'(-r4_det_reg) : DTW'(r4_det_reg);
            r5_neg_x_reg <= r4_nx_reg[NW-1] ^ r4_det_reg[DTW-1];
            r5_neg_y_reg <= r4_ny_reg[NW-1] ^ r4_det_reg[DTW-1];
            r5_sing_reg  <= (r4_det_reg == '0);
        end
    end

    // Stage 6: quotients too large for the divider's bit count are flagged here.
    tri2d_pkg::div_t r6_reg;
    logic [tri2d_pkg::DIV_W-1:0] top_dv;

    assign top_dv = tri2d_pkg::DIV_W'(r5_dv_reg) << QW;

    always_ff @(posedge clk)
    begin
        if (rdy6 && v5_reg)
        begin
            r6_reg.rem_x    <= tri2d_pkg::DIV_W'(r5_nx_reg);
            r6_reg.rem_y    <= tri2d_pkg::DIV_W'(r5_ny_reg);
            r6_reg.q_x      <= '0;
            r6_reg.q_y      <= '0;
            r6_reg.dv       <= r5_dv_reg;
            r6_reg.neg_x    <= r5_neg_x_reg;
            r6_reg.neg_y    <= r5_neg_y_reg;
            r6_reg.ovf_x    <= tri2d_pkg::DIV_W'(r5_nx_reg) >= top_dv;
            r6_reg.ovf_y    <= tri2d_pkg::DIV_W'(r5_ny_reg) >= top_dv;
            r6_reg.singular <= r5_sing_reg;
        end
    end

    // Divider pipeline: one quotient bit per stage, most significant first.
    assign div_valid[0]  = v6_reg;
    assign div_data[0]   = r6_reg;
    assign div_in_ready  = div_ready[0];
    assign div_ready[QW] = rdy_out;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        tri2d_div_step #(
            .SHIFT (CW - j)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[j]),
            .in_ready  (div_ready[j]),
            .in_data   (div_data[j]),
            .out_valid (div_valid[j+1]),
            .out_ready (div_ready[j+1]),
            .out_data  (div_data[j+1])
        );
    end

    // Output stage: sign, saturation and the singular override.
    tri2d_pkg::div_t fin;
    tri2d_pkg::out_t out_next;
    tri2d_pkg::out_t out_reg;
    logic            sat_x, sat_y;
    logic [QW-1:0]   nq_x, nq_y;

    always_comb
    begin
        fin   = div_data[QW];
        nq_x  = ~fin.q_x + QW'(1);
        nq_y  = ~fin.q_y + QW'(1);
        sat_x = fin.ovf_x || (fin.neg_x ? (fin.q_x > Q_HALF) : (fin.q_x >= Q_HALF));
        sat_y = fin.ovf_y || (fin.neg_y ? (fin.q_y > Q_HALF) : (fin.q_y >= Q_HALF));
        out_next.tag_x = fin.neg_x ? (sat_x ? C_MIN : $signed(nq_x[CW-1:0]))
                                   : (sat_x ? C_MAX : $signed(fin.q_x[CW-1:0]));
        out_next.tag_y = fin.neg_y ? (sat_y ? C_MIN : $signed(nq_y[CW-1:0]))
                                   : (sat_y ? C_MAX : $signed(fin.q_y[CW-1:0]));
        out_next.singular  = fin.singular;
        out_next.saturated = !fin.singular && (sat_x || sat_y);
        if (fin.singular)
        begin
            out_next.tag_x = '0;
            out_next.tag_y = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out && div_valid[QW])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    `include "trilateration_2d_solver_top_assert.svh"

    `TRI2D_CHECK(a_drain_ready, !out_valid |-> in_ready, "pipeline stalls with empty output")
    `TRI2D_CHECK_OUT(a_singular_zero,
        !out_data.singular || (out_data.tag_x == '0 && out_data.tag_y == '0
        && !out_data.saturated), "singular result is not cleared")
    `TRI2D_CHECK_OUT(a_sat_extreme,
        !out_data.saturated || out_data.tag_x == C_MAX || out_data.tag_x == C_MIN
        || out_data.tag_y == C_MAX || out_data.tag_y == C_MIN,
        "saturated result is not at a range limit")

endmodule
`default_nettype wire

FILE: rtl/tri2d_div_step.sv
// One restoring-division step for both coordinates, with its pipeline register.
`default_nettype none
module tri2d_div_step #(
    parameter int SHIFT = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire tri2d_pkg::div_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output tri2d_pkg::div_t       out_data
);

    logic            valid_reg;
    tri2d_pkg::div_t data_reg;
    tri2d_pkg::div_t data_next;
    logic [tri2d_pkg::DIV_W-1:0] sub_dv;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Trial subtraction of the shifted divisor from each remainder.
    always_comb
    begin
        data_next = in_data;
        sub_dv    = tri2d_pkg::DIV_W'(in_data.dv) << SHIFT;
        if (in_data.rem_x >= sub_dv)
        begin
            data_next.rem_x    = in_data.rem_x - sub_dv;
            data_next.q_x[SHIFT] = 1'b1;
        end
        if (in_data.rem_y >= sub_dv)
        begin
            data_next.rem_y    = in_data.rem_y - sub_dv;
            data_next.q_y[SHIFT] = 1'b1;
        end
    end

    // Stage register; valid travels with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

FILE: tb/trilateration_2d_solver_top_test.sv
// Self-checking testbench for the pipelined 2D trilateration solver.
module trilateration_2d_solver_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 32;
    localparam longint CYCLE_LIMIT = 2000000;

    // Exact position solver, working in wide signed arithmetic.
    class position_board;
        logic signed [tri2d_pkg::COORD_W-1:0] anchor[tri2d_pkg::NUM_REGS];
        tri2d_pkg::out_t pending[$];
        int errors;

        function new();
            errors = 0;
            foreach (anchor[i]) anchor[i] = '0;
        endfunction

        function void set_anchor(logic [tri2d_pkg::IDX_W-1:0] idx,
                                 logic [tri2d_pkg::COORD_W-1:0] val);
            if (idx < tri2d_pkg::NUM_REGS) anchor[idx] = val;
        endfunction

        // Truncating divide, saturated to the coordinate range.
        function logic signed [tri2d_pkg::COORD_W-1:0] clip_quotient(
            logic signed [127:0] num, logic signed [127:0] det, ref bit sat);
            logic signed [127:0] q;
            logic signed [127:0] hi_lim;
            logic signed [127:0] lo_lim;
            hi_lim = (128'sd1 <<< (tri2d_pkg::COORD_W - 1)) - 1;
            lo_lim = -(128'sd1 <<< (tri2d_pkg::COORD_W - 1));
            q = num / det;
            if (q > hi_lim) begin
                sat = 1;
                return hi_lim[tri2d_pkg::COORD_W-1:0];
            end
            if (q < lo_lim) begin
                sat = 1;
                return lo_lim[tri2d_pkg::COORD_W-1:0];
            end
            return q[tri2d_pkg::COORD_W-1:0];
        endfunction

        function void note_request(tri2d_pkg::in_t req);
            logic signed [127:0] x1, y1, x2, y2, x3, y3, d1, d2, d3;
            logic signed [127:0] a11, a12, a21, a22, base, b1, b2, det;
            tri2d_pkg::out_t fix;
            bit sat;
            x1 = anchor[0]; y1 = anchor[1];
            x2 = anchor[2]; y2 = anchor[3];
            x3 = anchor[4]; y3 = anchor[5];
            d1 = {104'd0, req.range_to_first};
            d2 = {104'd0, req.range_to_second};
            d3 = {104'd0, req.range_to_third};
            a11 = 2 * (x2 - x1); a12 = 2 * (y2 - y1);
            a21 = 2 * (x3 - x1); a22 = 2 * (y3 - y1);
            base = x1 * x1 + y1 * y1;
            b1 = d1 * d1 - d2 * d2 + x2 * x2 + y2 * y2 - base;
            b2 = d1 * d1 - d3 * d3 + x3 * x3 + y3 * y3 - base;
            det = a11 * a22 - a12 * a21;
            sat = 0;
            fix = '0;
            if (det == 0) begin
                fix.singular = 1'b1;
            end else begin
                fix.tag_x = clip_quotient(b1 * a22 - a12 * b2, det, sat);
                fix.tag_y = clip_quotient(a11 * b2 - a21 * b1, det, sat);
                fix.saturated = sat;
            end
            pending.insert(pending.size(), fix);
        endfunction

        function void check_fix(tri2d_pkg::out_t got);
            tri2d_pkg::out_t want;
            if (pending.size() == 0) begin
                $error("position with no request outstanding: %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.tag_x !== want.tag_x) begin
                $error("tag_x expected %0d actual %0d", want.tag_x, got.tag_x);
                errors++;
            end
            if (got.tag_y !== want.tag_y) begin
                $error("tag_y expected %0d actual %0d", want.tag_y, got.tag_y);
                errors++;
            end
            if (got.singular !== want.singular) begin
                $error("singular expected %0b actual %0b", want.singular, got.singular);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated expected %0b actual %0b", want.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    tri2d_pkg::in_t in_data;
    logic out_valid;
    logic out_ready;
    tri2d_pkg::out_t out_data;
    logic cfg_write;
    logic [tri2d_pkg::IDX_W-1:0] cfg_index;
    logic [tri2d_pkg::COORD_W-1:0] cfg_data;

    position_board board;
    longint cycles = 0;
    bit stall_enable;

    trilateration_2d_solver_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("trilateration_2d_solver_top_test: errors");
            $finish;
        end
    end

    // Check every accepted position.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) board.check_fix(out_data);
    end

    // Receiver stalls follow a mode that changes every so often.
    always @(negedge clk)
    begin
        if (!stall_enable) out_ready <= 1'b1;
        else begin
            case (cycles[9:8])
                2'd0: out_ready <= 1'b1;
                2'd1: out_ready <= ($urandom_range(0, 3) != 0);
                2'd2: out_ready <= ($urandom_range(0, 1) != 0);
                default: out_ready <= (cycles[3:0] < 4'd3);
            endcase
        end
    end

    // Drive one range request and wait for its acceptance; valid stays up for the next one.
    task automatic send_ranges(logic [tri2d_pkg::RANGE_W-1:0] r1,
                               logic [tri2d_pkg::RANGE_W-1:0] r2,
                               logic [tri2d_pkg::RANGE_W-1:0] r3);
        tri2d_pkg::in_t req;
        req.range_to_first = r1;
        req.range_to_second = r2;
        req.range_to_third = r3;
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (!in_ready);
        board.note_request(req);
        @(negedge clk);
    endtask

    // Wait until all positions are back and the pipeline has drained.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    task automatic write_anchor(logic [tri2d_pkg::IDX_W-1:0] idx,
                                logic [tri2d_pkg::COORD_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        board.set_anchor(idx, val);
        @(negedge clk);
    endtask

    task automatic load_anchors(logic [tri2d_pkg::COORD_W-1:0] ax1,
                                logic [tri2d_pkg::COORD_W-1:0] ay1,
                                logic [tri2d_pkg::COORD_W-1:0] ax2,
                                logic [tri2d_pkg::COORD_W-1:0] ay2,
                                logic [tri2d_pkg::COORD_W-1:0] ax3,
                                logic [tri2d_pkg::COORD_W-1:0] ay3);
        write_anchor(tri2d_pkg::REG_ANCHOR1_X, ax1);
        write_anchor(tri2d_pkg::REG_ANCHOR1_Y, ay1);
        write_anchor(tri2d_pkg::REG_ANCHOR2_X, ax2);
        write_anchor(tri2d_pkg::REG_ANCHOR2_Y, ay2);
        write_anchor(tri2d_pkg::REG_ANCHOR3_X, ax3);
        write_anchor(tri2d_pkg::REG_ANCHOR3_Y, ay3);
        cfg_write <= 1'b0;
    endtask

    // Pick an anchor coordinate: half the time moderate, otherwise extreme or random over the full range.
    function automatic logic [tri2d_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return tri2d_pkg::COORD_W'($urandom());
            default: return tri2d_pkg::COORD_W'($urandom_range(0, 20000) - 10000);
        endcase
    endfunction

    // Ranges consistent with a random tag, with small noise, or raw noise.
    task automatic send_random_fix();
        int tx, ty;
        real dx, dy;
        logic [tri2d_pkg::RANGE_W-1:0] r[3];
        if ($urandom_range(0, 9) < 7) begin
            tx = $urandom_range(0, 40000) - 20000;
            ty = $urandom_range(0, 40000) - 20000;
            for (int k = 0; k < 3; k++) begin
                dx = tx - board.anchor[2 * k];
                dy = ty - board.anchor[2 * k + 1];
                r[k] = tri2d_pkg::RANGE_W'($rtoi($sqrt(dx * dx + dy * dy))
                                          + $urandom_range(0, 20) - 10);
            end
        end else begin
            for (int k = 0; k < 3; k++) r[k] = tri2d_pkg::RANGE_W'($urandom());
        end
        send_ranges(r[0], r[1], r[2]);
    endtask

    // Random bursts of fixes, with a random gap after some bursts.
    task automatic run_random(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst && sent < count; i++) begin
                send_random_fix();
                sent++;
            end
            if ($urandom_range(0, 2) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        board = new();
        stall_enable = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b1;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset anchors all coincide, so every fix is singular.
        send_ranges(24'd0, 24'd0, 24'd0);
        send_ranges(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        drain_pipeline();

        // Well-spread anchors with field extremes.
        load_anchors(24'd0, 24'd0, 24'd10000, 24'd0, 24'd0, 24'd10000);
        send_ranges(24'd0, 24'd10000, 24'd10000);
        send_ranges(24'd7071, 24'd7071, 24'd7071);
        send_ranges(24'hFFFFFF, 24'd0, 24'd0);
        send_ranges(24'd0, 24'hFFFFFF, 24'd0);
        send_ranges(24'd0, 24'd0, 24'hFFFFFF);
        send_ranges(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        send_ranges(24'h555555, 24'hAAAAAA, 24'h555555);
        drain_pipeline();

        // Collinear anchors are singular.
        load_anchors(24'd0, 24'd0, 24'd1000, 24'd1000, -24'sd2000, -24'sd2000);
        send_ranges(24'd500, 24'd600, 24'd700);
        drain_pipeline();

        // Extreme anchor positions; both saturation directions.
        load_anchors(24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000,
                     24'h800000, 24'h7FFFFF);
        send_ranges(24'd0, 24'd0, 24'd0);
        send_ranges(24'hFFFFFF, 24'd0, 24'd0);
        send_ranges(24'd0, 24'hFFFFFF, 24'hFFFFFF);
        drain_pipeline();
        load_anchors(24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd1);
        send_ranges(24'd0, 24'hFFFFFF, 24'hFFFFFF);
        send_ranges(24'hFFFFFF, 24'd0, 24'd0);
        send_ranges(24'hFFFFFF, 24'd0, 24'hFFFFFF);
        drain_pipeline();

        // Random phases under receiver back-pressure.
        stall_enable = 1'b1;
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 8)
                load_anchors(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
                             24'h7FFFFF, 24'h7FFFFF);
            else
                load_anchors(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                             pick_coord(), pick_coord());
            run_random(75);
            // Hold the sender until every position is back.
            while (board.pending.size() != 0) @(negedge clk);
            run_random(75);
            drain_pipeline();
        end

        drain_pipeline();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("trilateration_2d_solver_top_test: clean");
        else
            $display("trilateration_2d_solver_top_test: errors");
        $finish;
    end
endmodule
